/* sv/bmp_stream_to_palette_and_frame_unit_defines.svh */
// Assertion macros used by the checker file of the bitmap loader.
`ifndef BMP_STREAM_TO_PALETTE_AND_FRAME_UNIT_DEFINES_SVH
`define BMP_STREAM_TO_PALETTE_AND_FRAME_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define BMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bmp_pkg.sv */
// Shared types and codes of the bitmap loader.
`default_nettype none

package bmp_pkg;

  // result kinds
  localparam logic [1:0] KIND_PALETTE = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PALETTE_BASE = 2'd2;

  localparam int ADDR_W = 24;

  typedef struct packed {
    logic [1:0]        out_kind;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_value;
    logic              load_done;
  } bmp_result_t;

endpackage

`default_nettype wire

/* sv/bmp_in_if.sv */
// Input byte stream channel.
`default_nettype none

interface bmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

/* sv/bmp_out_if.sv */
// Result channel: palette writes, pixel writes and the signature error.
`default_nettype none

interface bmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [23:0] write_address;
  logic [7:0]  write_value;
  logic        load_done;

  modport source (output valid, output out_kind, output write_address,
                  output write_value, output load_done, input ready);
  modport sink   (input valid, input out_kind, input write_address,
                  input write_value, input load_done, output ready);
endinterface

`default_nettype wire

/* sv/bmp_cfg.sv */
// APB register file and the bottom-row base product.
`default_nettype none

module bmp_cfg #(
  parameter int DIM_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic      [DIM_BITS-1:0]   frame_width,
  output logic      [DIM_BITS-1:0]   frame_height,
  output logic      [7:0]            palette_base,
  output logic      [bmp_pkg::ADDR_W-1:0] bottom_base
);
  import bmp_pkg::*;

  localparam int PROD_W = 2 * DIM_BITS;

  logic [DIM_BITS-1:0] width_r, height_r;
  logic [7:0]          base_r;
  logic [PROD_W-1:0]   prod;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // width * (height - 1) from the live registers: base address of the bottom row
  assign prod = PROD_W'(width_r) * PROD_W'(height_r - DIM_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_BITS'(320);
      height_r <= DIM_BITS'(240);
      base_r   <= 8'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_r  <= pwdata[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: height_r <= pwdata[DIM_BITS-1:0];
        REG_PALETTE_BASE: base_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(width_r);
      REG_FRAME_HEIGHT: prdata = 32'(height_r);
      REG_PALETTE_BASE: prdata = 32'(base_r);
      default:          prdata = 32'd0;
    endcase
  end

  assign frame_width  = width_r;
  assign frame_height = height_r;
  assign palette_base = base_r;
  assign bottom_base  = ADDR_W'(prod);

endmodule

`default_nettype wire

/* sv/bmp_parse.sv */
// Parser state machine: header, palette and pixel phases, one byte per step.
`default_nettype none

module bmp_parse #(
  parameter int DIM_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step_en,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       first_byte,
  input  wire logic [DIM_BITS-1:0]        frame_width,
  input  wire logic [DIM_BITS-1:0]        frame_height,
  input  wire logic [7:0]                 palette_base,
  input  wire logic [bmp_pkg::ADDR_W-1:0] bottom_base,
  output logic                            res_valid,
  output bmp_pkg::bmp_result_t            res
);
  import bmp_pkg::*;

  localparam logic [7:0] SIG_B          = 8'h42;
  localparam logic [7:0] SIG_M          = 8'h4D;
  localparam logic [5:0] POS_COUNT_LO   = 6'd46;
  localparam logic [5:0] POS_COUNT_HI   = 6'd47;
  localparam logic [5:0] POS_HEADER_END = 6'd53;
  localparam logic [16:0] FULL_PALETTE  = 17'd256;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_PALETTE, PH_PIXELS, PH_IGNORE
  } phase_t;

  phase_t              phase_r, phase_nxt, phase_e;
  logic [5:0]          hpos_r, hpos_nxt, hpos_e;
  logic [16:0]         count_r, count_nxt, count_e, count_upd;
  logic [16:0]         entry_r, entry_nxt, entry_e, entry_inc;
  logic [1:0]          comp_r, comp_nxt, comp_e;
  logic [DIM_BITS-1:0] col_r, col_nxt, col_e;
  logic [DIM_BITS-1:0] row_r, row_nxt, row_e;
  logic [ADDR_W-1:0]   rbase_r, rbase_nxt, rbase_e;
  logic [ADDR_W-1:0]   pal_sum, pal_addr, pix_addr;
  logic [DIM_BITS:0]   col_inc, row_inc;
  logic                sig_bad;

  always_comb begin
    // a first byte restarts parsing with this byte at offset zero
    phase_e = first_byte ? PH_HEADER : phase_r;
    hpos_e  = first_byte ? 6'd0 : hpos_r;
    count_e = first_byte ? 17'd0 : count_r;
    entry_e = first_byte ? 17'd0 : entry_r;
    comp_e  = first_byte ? 2'd0 : comp_r;
    col_e   = first_byte ? '0 : col_r;
    row_e   = first_byte ? '0 : row_r;
    rbase_e = first_byte ? '0 : rbase_r;

    sig_bad = ((hpos_e == 6'd0) && (data_byte != SIG_B)) ||
              ((hpos_e == 6'd1) && (data_byte != SIG_M));

    count_upd = count_e;
    if (hpos_e == POS_COUNT_LO)
      count_upd = 17'(data_byte);
    else if (hpos_e == POS_COUNT_HI)
      count_upd = count_e | {1'b0, data_byte, 8'd0};

    entry_inc = entry_e + 17'd1;
    pal_sum   = ADDR_W'(palette_base) + ADDR_W'(entry_e);
    pal_addr  = pal_sum + (pal_sum << 1) + ADDR_W'(2'd2 - comp_e);
    pix_addr  = rbase_e + ADDR_W'(col_e);
    col_inc   = {1'b0, col_e} + (DIM_BITS+1)'(1);
    row_inc   = {1'b0, row_e} + (DIM_BITS+1)'(1);

    phase_nxt = phase_e;
    hpos_nxt  = hpos_e;
    count_nxt = count_e;
    entry_nxt = entry_e;
    comp_nxt  = comp_e;
    col_nxt   = col_e;
    row_nxt   = row_e;
    rbase_nxt = rbase_e;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_e)
      PH_HEADER: begin
        if (sig_bad) begin
          phase_nxt    = PH_IGNORE;
          res_valid    = 1'b1;
          res.out_kind = KIND_ERROR;
        end else begin
          count_nxt = count_upd;
          if (hpos_e >= POS_HEADER_END) begin
            if (count_upd == 17'd0) count_nxt = FULL_PALETTE;
            entry_nxt = 17'd0;
            comp_nxt  = 2'd0;
            phase_nxt = PH_PALETTE;
          end else begin
            hpos_nxt = hpos_e + 6'd1;
          end
        end
      end
      PH_PALETTE: begin
        if (comp_e != 2'd3) begin
          // B, G, R go to +2, +1, +0 of the entry
          comp_nxt          = comp_e + 2'd1;
          res_valid         = 1'b1;
          res.out_kind      = KIND_PALETTE;
          res.write_address = pal_addr;
          res.write_value   = {2'b00, data_byte[7:2]};
        end else begin
          // reserved byte closes the entry
          comp_nxt  = 2'd0;
          entry_nxt = entry_inc;
          if (entry_inc >= count_e) begin
            col_nxt = '0;
            row_nxt = '0;
            if ((frame_width == '0) || (frame_height == '0)) begin
              phase_nxt = PH_IGNORE;
            end else begin
              rbase_nxt = bottom_base;
              phase_nxt = PH_PIXELS;
            end
          end
        end
      end
      PH_PIXELS: begin
        res_valid         = 1'b1;
        res.out_kind      = KIND_PIXEL;
        res.write_address = pix_addr;
        res.write_value   = data_byte;
        if (col_inc >= {1'b0, frame_width}) begin
          col_nxt = '0;
          if (row_inc >= {1'b0, frame_height}) begin
            res.load_done = 1'b1;
            phase_nxt     = PH_IGNORE;
          end else begin
            row_nxt   = row_inc[DIM_BITS-1:0];
            rbase_nxt = rbase_e - ADDR_W'(frame_width);
          end
        end else begin
          col_nxt = col_inc[DIM_BITS-1:0];
        end
      end
      PH_IDLE, PH_IGNORE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hpos_r  <= '0;
      count_r <= '0;
      entry_r <= '0;
      comp_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      rbase_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      count_r <= count_nxt;
      entry_r <= entry_nxt;
      comp_r  <= comp_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rbase_r <= rbase_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/bmp_stream_to_palette_and_frame_unit.sv */
// A byte accepted into the input register gives its result in the output register
// on its parser step, one short pass between two registers; one byte per cycle unless
// out_m stalls. Bytes that produce no result still take one step through the parser.
// Reset: synchronous, active low; parser idles until a first byte, config regs
// return to 320 x 240 with palette base 0, both pipeline registers empty.
`default_nettype none

module bmp_stream_to_palette_and_frame_unit #(
  parameter int DIM_BITS = 12
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  bmp_in_if.sink            in_s,
  bmp_out_if.source         out_m,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  import bmp_pkg::*;

  // input stage
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_first_r;

  // output stage
  logic        out_valid_r;
  bmp_result_t out_r;

  // parser step fires when an item is held and the output slot is free
  // (empty, or being taken in this cycle)
  logic        out_free;
  logic        step_en;

  logic [DIM_BITS-1:0] frame_width, frame_height;
  logic [7:0]          palette_base;
  logic [ADDR_W-1:0]   bottom_base;
  logic                res_valid;
  bmp_result_t         res;

  assign out_free = !out_valid_r || out_m.ready;
  assign step_en  = in_valid_r && out_free;
  // new byte enters when none is held or the held one leaves in this cycle
  assign in_s.ready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      in_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      in_byte_r  <= in_s.data_byte;
      in_first_r <= in_s.first_byte;
    end
  end

  bmp_cfg #(.DIM_BITS(DIM_BITS)) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .palette_base (palette_base),
    .bottom_base  (bottom_base)
  );

  bmp_parse #(.DIM_BITS(DIM_BITS)) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .data_byte    (in_byte_r),
    .first_byte   (in_first_r),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .palette_base (palette_base),
    .bottom_base  (bottom_base),
    .res_valid    (res_valid),
    .res          (res)
  );

  // result register; a step with no result leaves the slot empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= res_valid;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_r <= res;
    end
  end

  assign out_m.valid         = out_valid_r;
  assign out_m.out_kind      = out_r.out_kind;
  assign out_m.write_address = out_r.write_address;
  assign out_m.write_value   = out_r.write_value;
  assign out_m.load_done     = out_r.load_done;

endmodule

`default_nettype wire

/* sv/bmp_chk.sv */
// Port-level checker for the bitmap loader, bound to the top level.
`default_nettype none
`include "bmp_stream_to_palette_and_frame_unit_defines.svh"

module bmp_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [23:0] write_address,
  input wire logic [7:0]  write_value,
  input wire logic        load_done
);
  import bmp_pkg::*;

  `BMP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BMP_ASSERT(a_err_zero, out_valid && (out_kind == KIND_ERROR) |-> (write_address == 24'd0) && (write_value == 8'd0) && !load_done, "error result with payload")
  `BMP_ASSERT(a_pal_range, out_valid && (out_kind == KIND_PALETTE) |-> (write_value[7:6] == 2'b00) && !load_done, "palette write out of range")
  `BMP_ASSERT(a_kind_ok, out_valid |-> (out_kind == KIND_PALETTE) || (out_kind == KIND_PIXEL) || (out_kind == KIND_ERROR), "bad result kind")
  `BMP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind bmp_stream_to_palette_and_frame_unit bmp_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_m.valid),
  .out_ready     (out_m.ready),
  .out_kind      (out_m.out_kind),
  .write_address (out_m.write_address),
  .write_value   (out_m.write_value),
  .load_done     (out_m.load_done)
);

`default_nettype wire
